[rtl/fifo_wait_mutex_assert.svh]
// ----------------------------------------------------------------------------
// fifo_wait_mutex_assert.svh
// Assertion macros shared by the mutex block. Clock is i_clk, reset i_rst_n.
// ----------------------------------------------------------------------------
`ifndef FIFO_WAIT_MUTEX_ASSERT_SVH
`define FIFO_WAIT_MUTEX_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define FWM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("mutex assertion failed");

// Next-cycle implication, checked out of reset
`define FWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("mutex assertion failed");

`endif

[rtl/fwm_pkg.sv]
// ----------------------------------------------------------------------------
// fwm_pkg
// Types and codes shared by the mutex controller, datapath and top level.
// ----------------------------------------------------------------------------
package fwm_pkg;

    localparam int TASK_W = 6;
    localparam int OP_W   = 2;
    localparam int ST_W   = 3;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_LOCK    = 2'd0,
        OP_TRYLOCK = 2'd1,
        OP_UNLOCK  = 2'd2,
        OP_DESTROY = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_QUEUED   = 3'd1,
        ST_DEADLOCK = 3'd2,
        ST_BUSY     = 3'd3,
        ST_NOTOWNER = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_WAKE = 2'd2
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic busy;         // input channel stalled
        logic load_in;      // capture the accepted item
        logic commit;       // finish a non-wake operation
        logic rd_head;      // read the queue head entry
        logic wake_commit;  // hand the mutex to the queue head
    } t_ctrl_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic is_wake;      // unlock by owner with waiters queued
        logic out_free;     // output register can take a result
    } t_ctrl_stat;

endpackage

[rtl/fwm_ram.sv]
// ----------------------------------------------------------------------------
// fwm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fwm_ram #(
    parameter int DATA_W = 6,
    parameter int DEPTH  = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/fwm_ctrl.sv]
// ----------------------------------------------------------------------------
// fwm_ctrl
// Sequencer for the mutex: accept, execute, optional queue-head wake.
// ----------------------------------------------------------------------------
module fwm_ctrl
    import fwm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_ctrl_stat i_stat,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.busy = 1'b1;
                if (i_stat.is_wake) begin
                    // head entry needs a RAM read first
                    o_cmd.rd_head = 1'b1;
                    n_state       = S_WAKE;
                end else if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_WAKE: begin
                o_cmd.busy = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.wake_commit = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/fwm_dp.sv]
// ----------------------------------------------------------------------------
// fwm_dp
// Mutex datapath: owner state, wait queue pointers, queue RAM, result register.
// ----------------------------------------------------------------------------
module fwm_dp
    import fwm_pkg::*;
#(
    parameter int MAX_TASKS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl_cmd         i_cmd,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [TASK_W-1:0] i_task_id,
    input  logic              i_stall,
    output t_ctrl_stat        o_stat,
    output logic              o_valid,
    output logic [ST_W-1:0]   o_status,
    output logic              o_woken_valid,
    output logic [TASK_W-1:0] o_woken_task,
    output logic              o_owner_valid,
    output logic [TASK_W-1:0] o_owner_task
);

    localparam int AW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_TASKS - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_TASKS);

    // Captured item
    t_op               r_op;
    logic [TASK_W-1:0] r_task;

    // Mutex and queue state
    logic              r_held,   n_held;
    logic [TASK_W-1:0] r_holder, n_holder;
    logic [AW-1:0]     r_head,   n_head;
    logic [AW-1:0]     r_tail,   n_tail;
    logic [CW-1:0]     r_count,  n_count;

    // Result register
    logic              r_out_valid, n_out_valid;
    t_status           r_status;
    logic              r_woken_valid;
    logic [TASK_W-1:0] r_woken_task;
    logic              r_owner_valid;
    logic [TASK_W-1:0] r_owner_task;

    logic              holder_match;
    logic              q_empty;
    logic              q_full;
    logic              push;
    t_status           c_status;
    logic              c_held;
    logic [TASK_W-1:0] c_holder;
    logic [TASK_W-1:0] head_data;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
        ring_next = (idx == LAST_IDX) ? '0 : idx + AW'(1);
    endfunction

    assign holder_match = r_held && (r_holder == r_task);
    assign q_empty      = (r_count == '0);
    assign q_full       = (r_count == FULL_CNT);

    assign o_stat.is_wake  = (r_op == OP_UNLOCK) && holder_match && !q_empty;
    assign o_stat.out_free = !r_out_valid || !i_stall;

    // Decision for every operation except the wake
    always_comb begin
        c_status = ST_OK;
        c_held   = r_held;
        c_holder = r_holder;
        push     = 1'b0;
        case (r_op)
            OP_LOCK: begin
                if (holder_match) begin
                    c_status = ST_DEADLOCK;
                end else if (r_held && q_full) begin
                    c_status = ST_FULL;
                end else if (r_held) begin
                    c_status = ST_QUEUED;
                    push     = 1'b1;
                end else begin
                    c_held   = 1'b1;
                    c_holder = r_task;
                end
            end
            OP_TRYLOCK: begin
                if (r_held) begin
                    c_status = ST_BUSY;
                end else begin
                    c_held   = 1'b1;
                    c_holder = r_task;
                end
            end
            OP_UNLOCK: begin
                if (!holder_match) begin
                    c_status = ST_NOTOWNER;
                end else begin
                    // queue empty here: wake goes the other way
                    c_held   = 1'b0;
                    c_holder = '0;
                end
            end
            default: begin
                if (r_held) begin
                    c_status = ST_BUSY;
                end
            end
        endcase
    end

    // Next state
    always_comb begin
        n_held      = r_held;
        n_holder    = r_holder;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_stall;
        if (i_cmd.commit) begin
            n_held      = c_held;
            n_holder    = c_holder;
            n_out_valid = 1'b1;
            if (push) begin
                n_tail  = ring_next(r_tail);
                n_count = r_count + CW'(1);
            end
        end else if (i_cmd.wake_commit) begin
            n_holder    = head_data;
            n_head      = ring_next(r_head);
            n_count     = r_count - CW'(1);
            n_out_valid = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= 1'b0;
            r_holder    <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_held      <= n_held;
            r_holder    <= n_holder;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Item capture and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op   <= t_op'(i_operation);
            r_task <= i_task_id;
        end
        if (i_cmd.commit) begin
            r_status      <= c_status;
            r_woken_valid <= 1'b0;
            r_woken_task  <= '0;
            r_owner_valid <= c_held;
            r_owner_task  <= c_held ? c_holder : '0;
        end else if (i_cmd.wake_commit) begin
            r_status      <= ST_OK;
            r_woken_valid <= 1'b1;
            r_woken_task  <= head_data;
            r_owner_valid <= 1'b1;
            r_owner_task  <= head_data;
        end
    end

    // Wait queue storage
    fwm_ram #(
        .DATA_W (TASK_W),
        .DEPTH  (MAX_TASKS)
    ) u_queue (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.commit && push),
        .i_wr_addr (r_tail),
        .i_wr_data (r_task),
        .i_rd_en   (i_cmd.rd_head),
        .i_rd_addr (r_head),
        .o_rd_data (head_data)
    );

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_woken_valid = r_woken_valid;
    assign o_woken_task  = r_woken_task;
    assign o_owner_valid = r_owner_valid;
    assign o_owner_task  = r_owner_task;

endmodule

[rtl/fifo_wait_mutex.sv]
// Flow: an accepted item is captured, then decided in execute and committed to the
// output register; an unlock that wakes a waiter first does a registered read of the
// queue RAM, then commits in the wake state. One item in flight at a time; a stalled
// result holds the item in execute or wake until the output frees up.
// Reset: synchronous, active low; frees the mutex and empties the queue at once.
// ----------------------------------------------------------------------------
// fifo_wait_mutex
// Hardware mutex with a FIFO queue of waiting tasks: lock, trylock, unlock
// and destroy check, one status result per operation.
// ----------------------------------------------------------------------------
`include "fifo_wait_mutex_assert.svh"

module fifo_wait_mutex
    import fwm_pkg::*;
#(
    parameter int MAX_TASKS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [TASK_W-1:0] i_task_id,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [ST_W-1:0]   o_status,
    output logic              o_woken_valid,
    output logic [TASK_W-1:0] o_woken_task,
    output logic              o_owner_valid,
    output logic [TASK_W-1:0] o_owner_task
);

    t_ctrl_cmd  cmd;
    t_ctrl_stat stat;
    logic       owner_is_woken;

    // Sequencer
    fwm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Mutex state and queue
    fwm_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_operation   (i_operation),
        .i_task_id     (i_task_id),
        .i_stall       (i_stall),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_woken_valid (o_woken_valid),
        .o_woken_task  (o_woken_task),
        .o_owner_valid (o_owner_valid),
        .o_owner_task  (o_owner_task)
    );

    assign o_stall = cmd.busy;

    // Woken task became the owner
    assign owner_is_woken = o_owner_valid && (o_owner_task == o_woken_task);

    // Checks
    `FWM_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall)
    `FWM_ASSERT_IMP(a_wake_sets_owner, o_valid && o_woken_valid, owner_is_woken)
    `FWM_ASSERT_IMP(a_queued_needs_owner, o_valid && (o_status == ST_QUEUED), o_owner_valid)
    `FWM_ASSERT_IMP(a_free_owner_zero, o_valid && !o_owner_valid, o_owner_task == '0)

endmodule
